// ----- rtl/core/bds_pkg.sv -----
// bds_pkg: shared constants and controller/datapath interface structs
// for the baud divisor search block. No dependencies.
`default_nettype none
package bds_pkg;

    localparam logic [31:0] CORE_CLOCK_RESET      = 32'd48000000;
    localparam int          PRESCALER_COUNT_DEF   = 8;
    localparam int          DIVIDER_COUNT_DEF     = 9;

    // Index widths cover the full parameter range (counts up to 16).
    localparam int          PIDX_W                = 4;
    localparam int          DIDX_W                = 4;
    localparam int          DIVISOR_W             = PIDX_W + 1;
    localparam int          BUS_W                 = 31;
    localparam int          BIT_CNT_W             = 5;

    typedef struct packed {
        logic              take;       // latch request, clear nothing else
        logic              div_init;   // load bus clock and prescaler divisor
        logic              div_step;   // one restoring divide step
        logic              scan_step;  // evaluate one divider exponent
        logic              first;      // first pair of the scan
        logic              load_out;   // move best pair to output register
        logic [PIDX_W-1:0] p;
        logic [DIDX_W-1:0] d;
    } t_cmd;

    typedef struct packed {
        logic div_last;   // current divide step is the last one
        logic out_free;   // output register can take a result this cycle
    } t_sts;

endpackage
`default_nettype wire

// ----- rtl/core/bds_ctrl.sv -----
// bds_ctrl: search sequencer; walks prescaler and divider indexes and
// issues datapath commands. Depends on bds_pkg.
`default_nettype none
module bds_ctrl #(
    parameter int PRESCALER_COUNT = bds_pkg::PRESCALER_COUNT_DEF,
    parameter int DIVIDER_COUNT   = bds_pkg::DIVIDER_COUNT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire bds_pkg::t_sts i_sts,
    output bds_pkg::t_cmd      o_cmd
);
    import bds_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_INIT,
        S_DIV,
        S_SCAN,
        S_FINISH
    } t_state;

    localparam logic [PIDX_W-1:0] P_LAST = PIDX_W'(PRESCALER_COUNT - 1);
    localparam logic [DIDX_W-1:0] D_LAST = DIDX_W'(DIVIDER_COUNT - 1);

    t_state            r_state;
    logic [PIDX_W-1:0] r_p;
    logic [DIDX_W-1:0] r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p     <= '0;
            r_d     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_p     <= '0;
                        r_d     <= '0;
                        r_state <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT: begin
                    r_d     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_sts.div_last) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_d == D_LAST) begin
                        if (r_p == P_LAST) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_p     <= r_p + PIDX_W'(1);
                            r_state <= S_DIV_INIT;
                        end
                    end else begin
                        r_d <= r_d + DIDX_W'(1);
                    end
                end
                S_FINISH: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.p         = r_p;
        o_cmd.d         = r_d;
        o_cmd.take      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_init  = (r_state == S_DIV_INIT);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.first     = (r_p == '0) && (r_d == '0);
        o_cmd.load_out  = (r_state == S_FINISH) && i_sts.out_free;
    end

endmodule
`default_nettype wire

// ----- rtl/core/bds_dp.sv -----
// bds_dp: clock register, restoring divider, error compare, best-pair
// tracking and output register. Depends on bds_pkg.
`default_nettype none
module bds_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic [31:0]   i_target_baud,
    input  wire bds_pkg::t_cmd i_cmd,
    output bds_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [2:0]         o_best_prescaler,
    output logic [3:0]         o_best_divider,
    output logic [30:0]        o_achieved_baud,
    output logic [31:0]        o_baud_error
);
    import bds_pkg::*;

    logic [31:0]          r_core_clk;
    logic [31:0]          r_target;
    logic [BUS_W-1:0]     r_dvd;      // dividend in, quotient out
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_divisor;
    logic [BIT_CNT_W-1:0] r_bit;
    logic [31:0]          r_best_err;
    logic [BUS_W-1:0]     r_best_rate;
    logic [PIDX_W-1:0]    r_best_p;
    logic [DIDX_W-1:0]    r_best_d;
    logic                 r_out_valid;
    logic [2:0]           r_out_p;
    logic [3:0]           r_out_d;
    logic [30:0]          r_out_rate;
    logic [31:0]          r_out_err;

    logic [DIVISOR_W:0]   w_trial;
    logic                 w_ge;
    logic [DIVISOR_W:0]   w_diff;
    logic [BUS_W-1:0]     w_rate;
    logic [31:0]          w_rate_ext;
    logic [31:0]          w_err;
    logic                 w_take;

    assign w_trial    = {r_rem, r_dvd[BUS_W-1]};
    assign w_ge       = (w_trial >= {1'b0, r_divisor});
    assign w_diff     = w_trial - {1'b0, r_divisor};

    // Divider exponent d divides the prescaled clock by 2^(d+1).
    assign w_rate     = (r_dvd >> 1) >> i_cmd.d;
    assign w_rate_ext = {1'b0, w_rate};
    assign w_err      = (w_rate_ext < r_target) ? (r_target - w_rate_ext)
                                                : (w_rate_ext - r_target);
    assign w_take     = i_cmd.first || (w_err < r_best_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_clk  <= CORE_CLOCK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_core_clk <= i_cfg_data;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_target <= i_target_baud;
        end
        if (i_cmd.div_init) begin
            r_dvd     <= r_core_clk[31:1];
            r_rem     <= '0;
            r_divisor <= DIVISOR_W'(i_cmd.p) + DIVISOR_W'(1);
            r_bit     <= BIT_CNT_W'(BUS_W - 1);
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[BUS_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_bit <= r_bit - BIT_CNT_W'(1);
        end
        if (i_cmd.scan_step && w_take) begin
            r_best_err  <= w_err;
            r_best_rate <= w_rate;
            r_best_p    <= i_cmd.p;
            r_best_d    <= i_cmd.d;
        end
        if (i_cmd.load_out) begin
            r_out_p    <= 3'(r_best_p);
            r_out_d    <= 4'(r_best_d);
            r_out_rate <= r_best_rate;
            r_out_err  <= r_best_err;
        end
    end

    assign o_sts.div_last   = (r_bit == '0);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_best_prescaler = r_out_p;
    assign o_best_divider   = r_out_d;
    assign o_achieved_baud  = r_out_rate;
    assign o_baud_error     = r_out_err;

endmodule
`default_nettype wire

// ----- rtl/core/baud_divisor_search.sv -----
// baud_divisor_search: top level; ties the search sequencer to the datapath.
// Depends on bds_pkg, bds_ctrl, bds_dp.
//
// Usage:
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the core
//   clock in hertz; o_cfg_ready is always high. Write only while idle.
//   Input channel (i_in_valid / o_in_ready / i_target_baud) takes one
//   requested bit rate. Output channel (o_out_valid / i_out_ready) returns
//   the best prescaler code, divider exponent, achieved rate and error.
//   Each prescaler runs a 31-step restoring divide of the bus clock (one
//   quotient bit per cycle), then scans the divider exponents one by one
//   for shift, error and compare. One request at a time: o_in_ready is
//   high only while the sequencer idles. A result waits in the output
//   register; the next request may be taken meanwhile, and if the receiver
//   still stalls when that search finishes, the sequencer holds its result
//   until the register frees.
//   Reset: clock register returns to 48 MHz, no request or result pending.
//   Ties keep the first pair in prescaler-major order.
`default_nettype none
module baud_divisor_search #(
    parameter int PRESCALER_COUNT = bds_pkg::PRESCALER_COUNT_DEF,
    parameter int DIVIDER_COUNT   = bds_pkg::DIVIDER_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_target_baud,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_best_prescaler,
    output logic [3:0]       o_best_divider,
    output logic [30:0]      o_achieved_baud,
    output logic [31:0]      o_baud_error
);
    import bds_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Config request always lands at once.
    assign o_cfg_ready = 1'b1;

    bds_ctrl #(
        .PRESCALER_COUNT (PRESCALER_COUNT),
        .DIVIDER_COUNT   (DIVIDER_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bds_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_target_baud    (i_target_baud),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_best_prescaler (o_best_prescaler),
        .o_best_divider   (o_best_divider),
        .o_achieved_baud  (o_achieved_baud),
        .o_baud_error     (o_baud_error)
    );

    // Busy right after taking a request.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a request was taken");

    // Only one datapath command per cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.take, w_cmd.div_init, w_cmd.div_step,
                  w_cmd.scan_step, w_cmd.load_out}))
        else $error("conflicting datapath commands");

    // Never overwrite a result the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten while stalled");

    // Reported divider exponent stays within the scanned range.
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_best_divider) < 32'(DIVIDER_COUNT)))
        else $error("divider exponent out of range");

endmodule
`default_nettype wire
